@@ rtl/tccw_pkg.sv @@
// tccw_pkg: shared types and constants of the text console cell writer
// payload structs, operation codes and the controller/datapath command and status structs
// no dependencies
package tccw_pkg;

   localparam int CURSOR_POS_W = 11;
   localparam int CELL_W       = 16;
   localparam int CSR_INDEX_W  = 2;

   // item kinds
   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // character codes
   localparam logic [7:0] CH_BELL  = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_ATTRIBUTE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_CELL     = 2'd1;

   localparam logic [7:0]        RESET_ATTR  = 8'h07;
   localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

   // decoded operations
   localparam logic [2:0] OP_PUT     = 3'd0;
   localparam logic [2:0] OP_TAB     = 3'd1;
   localparam logic [2:0] OP_BS      = 3'd2;
   localparam logic [2:0] OP_NEWLINE = 3'd3;
   localparam logic [2:0] OP_CR      = 3'd4;
   localparam logic [2:0] OP_NOP     = 3'd5;
   localparam logic [2:0] OP_READ    = 3'd6;
   localparam logic [2:0] OP_CLEAR   = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_POS_W-1:0] cursor_pos;
      logic [CELL_W-1:0]       cell_data;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic put;
      logic back;
      logic newline;
      logic home_col;
      logic home;
      logic read_cell;
      logic cnt_clear;
      logic scroll_step;
      logic fill_step;
      logic fill_init;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       wrap;
      logic       last_row;
      logic       tab_end;
      logic       fill_last;
      logic       scroll_last;
      logic       rsp_free;
   } status_type;

endpackage

@@ rtl/tccw_ctrl.sv @@
// tccw_ctrl: sequencing state machine of the text console cell writer
// issues datapath commands from decoded status; uses tccw_pkg
module tccw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tccw_pkg::status_type  status,
   output tccw_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_TAB    = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_step = 1'b1;
            cmd.fill_init = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.op)
               tccw_pkg::OP_PUT: begin
                  cmd.put = 1'b1;
                  if (status.wrap && status.last_row) begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = ST_SCROLL;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               tccw_pkg::OP_TAB: begin
                  cmd.put = 1'b1;
                  if (status.wrap && status.last_row) begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = ST_SCROLL;
                  end else if (status.wrap || status.tab_end) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_TAB;
                  end
               end
               tccw_pkg::OP_BS: begin
                  cmd.back = 1'b1;
                  state_in = ST_RESP;
               end
               tccw_pkg::OP_NEWLINE: begin
                  cmd.newline = 1'b1;
                  if (status.last_row) begin
                     cmd.cnt_clear = 1'b1;
                     state_in      = ST_SCROLL;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               tccw_pkg::OP_CR: begin
                  cmd.home_col = 1'b1;
                  state_in     = ST_RESP;
               end
               tccw_pkg::OP_READ: begin
                  cmd.read_cell = 1'b1;
                  state_in      = ST_RESP;
               end
               tccw_pkg::OP_CLEAR: begin
                  cmd.home      = 1'b1;
                  cmd.cnt_clear = 1'b1;
                  state_in      = ST_CLEAR;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_TAB: begin
            // one space per cycle until the next stop or the end of the line
            cmd.put = 1'b1;
            if (status.wrap && status.last_row) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_SCROLL;
            end else if (status.wrap || status.tab_end) begin
               state_in = ST_RESP;
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) begin
               state_in = ST_RESP;
            end
         end
         ST_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not move to execute");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over an untaken beat");

   a_scroll_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL && !status.scroll_last) |=> (state_ff == ST_SCROLL))
      else $error("scroll copy left early");

endmodule

@@ rtl/tccw_dp.sv @@
// tccw_dp: datapath of the text console cell writer
// screen memory, cursor, registers, sweep counter and result register; uses tccw_pkg
module tccw_dp #(
   parameter int ROWS,
   parameter int COLS,
   parameter int TAB_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tccw_pkg::cmd_type                   cmd,
   output tccw_pkg::status_type                status,
   input  tccw_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tccw_pkg::CELL_W-1:0]         csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output tccw_pkg::rsp_type                   rsp_data
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int PH_W   = (TAB_SIZE > 1) ? $clog2(TAB_SIZE) : 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int POS_W  = tccw_pkg::CURSOR_POS_W;
   localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;
   localparam int CW     = tccw_pkg::CELL_W;

   tccw_pkg::req_type item_ff;
   tccw_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_m1;
   logic [7:0]        attr_ff;
   logic [CW-1:0]     blank_ff;
   logic [CW-1:0]     rd_data_ff;

   logic [CW-1:0]     mem [CELLS];

   logic [LIN_W-1:0]  lin, lin_m1, idx_ext;
   logic              hit, wrap, last_row, col_zero, tab_end;
   logic [2:0]        op;
   logic [7:0]        put_byte;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [CW-1:0]     mem_wr_data;

   assign lin      = LIN_W'(row_ff) * LIN_W'(COLS) + LIN_W'(col_ff);
   assign lin_m1   = lin - 1'b1;
   assign idx_ext  = LIN_W'(item_ff.cell_index);
   assign hit      = (32'(item_ff.cell_index) < CELLS);
   assign wrap     = (col_ff == COL_W'(COLS - 1));
   assign last_row = (row_ff == ROW_W'(ROWS - 1));
   assign col_zero = (col_ff == '0);
   assign tab_end  = (phase_ff == PH_W'(TAB_SIZE - 1));
   assign cnt_m1   = cnt_ff - 1'b1;
   assign put_byte = (op == tccw_pkg::OP_TAB) ? tccw_pkg::CH_SPACE : item_ff.char_code;

   always_comb begin
      case (item_ff.kind)
         tccw_pkg::KIND_CHAR: begin
            case (item_ff.char_code)
               tccw_pkg::CH_BS:   op = tccw_pkg::OP_BS;
               tccw_pkg::CH_HT:   op = tccw_pkg::OP_TAB;
               tccw_pkg::CH_LF:   op = tccw_pkg::OP_NEWLINE;
               tccw_pkg::CH_ESC:  op = tccw_pkg::OP_NEWLINE;
               tccw_pkg::CH_CR:   op = tccw_pkg::OP_CR;
               tccw_pkg::CH_BELL: op = tccw_pkg::OP_NOP;
               default:           op = tccw_pkg::OP_PUT;
            endcase
         end
         tccw_pkg::KIND_READ:  op = tccw_pkg::OP_READ;
         tccw_pkg::KIND_CLEAR: op = tccw_pkg::OP_CLEAR;
         default:              op = tccw_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      status.op          = op;
      status.wrap        = wrap;
      status.last_row    = last_row;
      status.tab_end     = tab_end;
      status.fill_last   = (cnt_ff == CNT_W'(CELLS - 1));
      status.scroll_last = (cnt_ff == CNT_W'(CELLS));
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // cursor and tab phase (phase tracks column modulo the tab size)
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      if (cmd.put) begin
         if (wrap) begin
            col_in   = '0;
            phase_in = '0;
            if (!last_row) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in   = col_ff + 1'b1;
            phase_in = tab_end ? '0 : phase_ff + 1'b1;
         end
      end else if (cmd.back) begin
         if (!col_zero) begin
            col_in   = col_ff - 1'b1;
            phase_in = (phase_ff == '0) ? PH_W'(TAB_SIZE - 1) : phase_ff - 1'b1;
         end
      end else if (cmd.newline) begin
         col_in   = '0;
         phase_in = '0;
         if (!last_row) begin
            row_in = row_ff + 1'b1;
         end
      end else if (cmd.home_col) begin
         col_in   = '0;
         phase_in = '0;
      end else if (cmd.home) begin
         row_in   = '0;
         col_in   = '0;
         phase_in = '0;
      end
   end

   always_comb begin
      mem_we      = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_re      = 1'b0;
      mem_rd_addr = '0;
      if (cmd.put) begin
         mem_we      = 1'b1;
         mem_wr_addr = lin[ADDR_W-1:0];
         mem_wr_data = {attr_ff, put_byte};
      end else if (cmd.back) begin
         mem_we      = !col_zero;
         mem_wr_addr = lin_m1[ADDR_W-1:0];
         mem_wr_data = blank_ff;
      end else if (cmd.scroll_step) begin
         // read the cell one row below into the read register, write it back one row up on the following step
         mem_we      = (cnt_ff != '0);
         mem_wr_addr = cnt_m1[ADDR_W-1:0];
         mem_wr_data = (cnt_ff <= CNT_W'(CELLS - COLS)) ? rd_data_ff : blank_ff;
      end else if (cmd.fill_step) begin
         mem_we      = 1'b1;
         mem_wr_addr = cnt_ff[ADDR_W-1:0];
         mem_wr_data = cmd.fill_init ? tccw_pkg::RESET_BLANK : blank_ff;
      end
      if (cmd.read_cell) begin
         mem_re      = hit;
         mem_rd_addr = idx_ext[ADDR_W-1:0];
      end else if (cmd.scroll_step) begin
         mem_re      = (cnt_ff < CNT_W'(CELLS - COLS));
         mem_rd_addr = ADDR_W'(cnt_ff + CNT_W'(COLS));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         phase_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end else if (cmd.scroll_step || cmd.fill_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= tccw_pkg::RESET_ATTR;
         blank_ff <= tccw_pkg::RESET_BLANK;
      end else if (csr_valid) begin
         case (csr_index)
            tccw_pkg::CSR_CHAR_ATTRIBUTE: attr_ff  <= csr_data[7:0];
            tccw_pkg::CSR_BLANK_CELL:     blank_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.cursor_pos = lin[POS_W-1:0];
      rsp_in.cell_data  = (op == tccw_pkg::OP_READ && hit) ? rd_data_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_wr_addr) < CELLS))
      else $error("screen write outside the cell range");

   a_put_is_char: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> (op == tccw_pkg::OP_PUT || op == tccw_pkg::OP_TAB))
      else $error("cell write for an item that writes no character");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("rsp beat dropped or changed while waiting");

endmodule

@@ rtl/text_console_cell_writer.sv @@
// text_console_cell_writer: top level of the text mode console engine
// joins tccw_ctrl and tccw_dp; uses tccw_pkg
//
// A screen of ROWS x COLS 16-bit cells is held in one memory with a write port and
// a registered read port. One item is worked on at a time; a beat is accepted in the
// idle state even while the previous result still waits on the rsp side. Printable
// characters, control codes, reads and unused kinds pass through accept, execute and
// load result, where the result waits until the rsp side is free. A tab writes one
// space per cycle up to the next tab stop or the end of the line. A line feed or
// escape on the last row, or a wrap past the last row, adds a scroll copying one cell
// per cycle through the memory port pair. A clear item adds a blank fill of every
// cell. After reset a clearing pass writes the reset blank word 0x0720 to every
// cell before the first beat is accepted; csr writes are taken at any time.
module text_console_cell_writer #(
   parameter int ROWS     = 25,
   parameter int COLS     = 80,
   parameter int TAB_SIZE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tccw_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tccw_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tccw_pkg::CELL_W-1:0]        csr_data
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_dp #(
      .ROWS     (ROWS),
      .COLS     (COLS),
      .TAB_SIZE (TAB_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
